@@ sv/occ_ub_pkg.sv @@
// Shared widths, constants, register indexes and the controller/datapath
// handshake types for the occupancy upper-bound check.
// No dependencies.
package occ_ub_pkg;

  localparam int DEF_LEN_BITS = 16;
  localparam int SUM_W        = 48;
  localparam int SUM_HALF     = 24;
  localparam int BOUND_W      = 64;
  localparam int CNT_W        = 17;
  localparam int THR_W        = 40;
  localparam int TQ_W         = THR_W + 16;
  localparam int ULEN_W       = 16;
  localparam int K_W          = 8;
  localparam int QUO_W        = 33;
  localparam int DIV_STEPS    = 33;
  localparam int STEP_W       = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 40;

  localparam logic [CNT_W-1:0]  CNT_CAP    = 17'd65536;
  localparam logic [SUM_W-1:0]  SUM_MAX    = '1;
  localparam logic [THR_W-1:0]  THR_RESET  = 40'd65536;
  localparam logic [ULEN_W-1:0] ULEN_RESET = 16'd1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAME_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIFORM_LEN = 2'd2;

  typedef struct packed {
    logic load;
    logic div_first;
    logic div_step;
    logic mul0;
    logic mul1;
    logic mul2;
    logic accum;
    logic fin0;
    logic fin1;
  } dp_cmd_t;

  typedef struct packed {
    logic close;
    logic last;
  } dp_status_t;

endpackage

@@ sv/occ_ub_datapath.sv @@
// Datapath: configuration registers, radix-2 reciprocal divider, split
// bound multiplier, list accumulators and the final threshold checks.
// Depends on occ_ub_pkg; driven by occ_ub_ctrl through dp_cmd_t.
module occ_ub_datapath #(
  parameter int LEN_BITS = occ_ub_pkg::DEF_LEN_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [occ_ub_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [occ_ub_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [LEN_BITS-1:0]              trans_len,
  input  logic [occ_ub_pkg::K_W-1:0]       itemset_len,
  input  logic                             last,
  input  occ_ub_pkg::dp_cmd_t              cmd,
  output occ_ub_pkg::dp_status_t           status,
  output logic                             accepted,
  output logic                             high_occupancy,
  output logic [occ_ub_pkg::CNT_W-1:0]     support
);
  import occ_ub_pkg::*;

  localparam int PP_W = LEN_BITS + SUM_HALF;

  logic [THR_W-1:0]    thr;
  logic                same_mode;
  logic [ULEN_W-1:0]   ulen;
  logic [ULEN_W-1:0]   ulen_fix;

  logic [LEN_BITS-1:0] len_fix;
  logic [LEN_BITS-1:0] len_r;
  logic [K_W-1:0]      k_r;
  logic                last_r;
  logic                close_r;

  logic [LEN_BITS-1:0] rem;
  logic [LEN_BITS:0]   trial;
  logic [LEN_BITS:0]   diff;
  logic                qbit;
  logic [QUO_W-1:0]    quo;

  logic [SUM_W-1:0]    sum;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_next;
  logic [BOUND_W-1:0]  best;
  logic [LEN_BITS-1:0] prev_len;
  logic [CNT_W-1:0]    count;

  logic [PP_W-1:0]     pp_lo;
  logic [PP_W-1:0]     pp_hi;
  logic [BOUND_W-1:0]  bound_cand;

  logic [TQ_W-1:0]     ks;
  logic [TQ_W-1:0]     tu;
  logic [K_W+CNT_W-1:0] kc;
  logic [TQ_W-1:0]     thr32;
  logic                cnt_ok;
  logic                bound_ok;
  logic                sum_ho;
  logic                uni_ho;
  logic                acc_next;
  logic                ho_next;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= THR_RESET;
      same_mode <= 1'b0;
      ulen      <= ULEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:   thr       <= cfg_data[THR_W-1:0];
        REG_SAME_MODE:   same_mode <= cfg_data[0];
        REG_UNIFORM_LEN: ulen      <= cfg_data[ULEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign ulen_fix = (ulen == '0) ? ULEN_W'(1) : ulen;
  assign len_fix  = (trans_len == '0) ? LEN_BITS'(1) : trans_len;

  // Restoring divider: 2^32 / len, dividend bits are a one then zeros
  assign trial = {rem, cmd.div_first};
  assign diff  = trial - {1'b0, len_r};
  assign qbit  = trial >= {1'b0, len_r};

  assign sum_add  = {1'b0, sum} + (SUM_W+1)'(quo);
  assign sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

  // Bound is taken modulo 2^64
  assign bound_cand = BOUND_W'(pp_lo) + (BOUND_W'(pp_hi) << SUM_HALF);

  assign thr32    = {thr, 16'b0};
  assign cnt_ok   = THR_W'({count, 16'b0}) >= thr;
  assign bound_ok = best >= BOUND_W'(thr32);
  assign sum_ho   = ks >= thr32;
  assign uni_ho   = TQ_W'({kc, 16'b0}) >= tu;
  assign acc_next = cnt_ok && (same_mode || bound_ok);
  assign ho_next  = cnt_ok && (same_mode ? uni_ho : (bound_ok && sum_ho));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len_r   <= len_fix;
      k_r     <= itemset_len;
      last_r  <= last;
      close_r <= (count != '0) && (len_fix < prev_len);
      rem     <= '0;
    end else if (cmd.div_step) begin
      rem <= qbit ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
      quo <= {quo[QUO_W-2:0], qbit};
    end
    // prev_len and sum are the old values during the divide, the new ones after
    if (cmd.mul0) pp_lo <= prev_len * sum[SUM_HALF-1:0];
    if (cmd.mul1) pp_hi <= prev_len * sum[SUM_W-1:SUM_HALF];
    if (cmd.fin0) begin
      ks <= k_r * sum;
      tu <= thr * ulen_fix;
      kc <= k_r * count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum            <= '0;
      best           <= '0;
      prev_len       <= '0;
      count          <= '0;
      accepted       <= 1'b0;
      high_occupancy <= 1'b0;
      support        <= '0;
    end else begin
      if (cmd.mul2 && (bound_cand > best)) begin
        best <= bound_cand;
      end
      if (cmd.accum) begin
        sum      <= sum_next;
        prev_len <= len_r;
        if (count < CNT_CAP) begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.fin1) begin
        accepted       <= acc_next;
        high_occupancy <= ho_next;
        support        <= count;
        // drop list state for the next itemset
        sum            <= '0;
        best           <= '0;
        prev_len       <= '0;
        count          <= '0;
      end
    end
  end

  assign status.close = close_r;
  assign status.last  = last_r;

  a_clear_after_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.fin1 |=> (count == '0) && (sum == '0) && (best == '0))
    else $error("list state not cleared after result");

  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && !cmd.div_first) |-> (rem < len_r))
    else $error("divider remainder out of range");

  a_ho_implies_acc: assert property (@(posedge clk) disable iff (rst)
    high_occupancy |-> accepted)
    else $error("high occupancy without acceptance");

endmodule

@@ sv/occ_ub_ctrl.sv @@
// Controller: sequences divide, bound multiply, accumulate and final check,
// and owns the request handshakes on both channels.
// Depends on occ_ub_pkg; drives occ_ub_datapath through dp_cmd_t.
module occ_ub_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  occ_ub_pkg::dp_status_t status,
  output occ_ub_pkg::dp_cmd_t    cmd
);
  import occ_ub_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIV  = 8'b0000_0010,
    ST_ACC  = 8'b0000_0100,
    ST_MUL0 = 8'b0000_1000,
    ST_MUL1 = 8'b0001_0000,
    ST_MUL2 = 8'b0010_0000,
    ST_FIN0 = 8'b0100_0000,
    ST_FIN1 = 8'b1000_0000
  } state_t;

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    step_next  = step;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (step == '0);
        // a drop in length closes the previous group while the divider runs
        cmd.mul0 = status.close && (step == STEP_W'(0));
        cmd.mul1 = status.close && (step == STEP_W'(1));
        cmd.mul2 = status.close && (step == STEP_W'(2));
        if (step == DIV_LAST) begin
          state_next = ST_ACC;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_ACC: begin
        cmd.accum  = 1'b1;
        state_next = status.last ? ST_MUL0 : ST_IDLE;
      end
      ST_MUL0: begin
        cmd.mul0   = 1'b1;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_FIN0;
      end
      ST_FIN0: begin
        cmd.fin0   = 1'b1;
        state_next = ST_FIN1;
      end
      ST_FIN1: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.fin1   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = cmd.fin1 ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.fin1 |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_mul_order: assert property (@(posedge clk) disable iff (rst)
    cmd.mul2 |-> $past(cmd.mul1))
    else $error("bound compare without high partial product");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_DIV) && (step == '0))
    else $error("request accepted without starting divide");

endmodule

@@ sv/occupancy_upper_bound_check_core.sv @@
// Top level of the occupancy upper-bound check: controller plus datapath.
// Depends on occ_ub_pkg, occ_ub_ctrl and occ_ub_datapath.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   input   | in_valid / in_ready   | trans_len, itemset_len, last
//   output  | out_valid / out_ready | accepted, high_occupancy, support
//   config  | cfg_we                | cfg_index, cfg_data (no wait, no read-back)
//
// An element passes from the idle state through the 33 steps of the radix-2
// reciprocal divider and the accumulate state before the next request is taken.
// The last element of a list adds the bound-multiply states MUL0 to MUL2 and the
// check states FIN0 and FIN1, where its result is registered. Synchronous reset, no clearing pass.
// A result waits in the output register while the next list is taken in; the
// next list's final check holds until that result is taken.
module occupancy_upper_bound_check_core #(
  parameter int LEN_BITS = occ_ub_pkg::DEF_LEN_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [occ_ub_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [occ_ub_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [LEN_BITS-1:0]               trans_len,
  input  logic [occ_ub_pkg::K_W-1:0]        itemset_len,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              accepted,
  output logic                              high_occupancy,
  output logic [occ_ub_pkg::CNT_W-1:0]      support
);
  import occ_ub_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  occ_ub_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  occ_ub_datapath #(
    .LEN_BITS (LEN_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .trans_len      (trans_len),
    .itemset_len    (itemset_len),
    .last           (last),
    .cmd            (cmd),
    .status         (status),
    .accepted       (accepted),
    .high_occupancy (high_occupancy),
    .support        (support)
  );

endmodule
